// ===== hw/rtl/aact_pkg.sv =====
// ---------------------------------------------------------------------------
// aact_pkg - shared types and constants of the array access coverage tracker
// Entry statistics record, operation codes, hash constants and the helper
// that builds the byte weights for reducing an index modulo the slot count.
// ---------------------------------------------------------------------------
package aact_pkg;

  // operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // distinct slot counter covers the largest slot count
  localparam int DIST_W = 13;

  // index reduction: byte-weighted sum width and reciprocal shift
  localparam int FOLD_W = 24;

  // coverage hash
  localparam logic [31:0] HASH_MUL  = 32'h85ebca6b;
  localparam int          HASH_SH_I = 5;
  localparam int          HASH_SH_A = 16;
  localparam int          HASH_SH_B = 13;
  localparam int          HASH_W    = 29;

  typedef struct packed {
    logic [31:0]       count;
    logic [63:0]       min_idx;
    logic [63:0]       max_idx;
    logic [DIST_W-1:0] distinct;
  } stat_t;

  // 256^k mod s, reduced by shifted subtraction
  function automatic logic [11:0] fold_weight(input int k, input int s);
    int c;
    c = 1;
    for (int i = 0; i < k; i++) begin
      c = c * 256;
      for (int b = 8; b >= 0; b--) begin
        if (c >= (s << b)) begin
          c = c - (s << b);
        end
      end
    end
    return 12'(c);
  endfunction

endpackage

// ===== hw/rtl/aact_ram.sv =====
// ---------------------------------------------------------------------------
// aact_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module aact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/aact_cell.sv =====
// ---------------------------------------------------------------------------
// aact_cell - one tracked-id cell of the lookup chain
// Holds one array id and its valid flag, compares it against the query and
// passes the accumulated hit and entry index on to the next cell.
// ---------------------------------------------------------------------------
module aact_cell #(
  parameter int EW    = 6,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [31:0]   wr_id,
  input  logic [31:0]   q_id,
  input  logic          hit_in,
  input  logic [EW-1:0] idx_in,
  output logic          match,
  output logic          hit_out,
  output logic [EW-1:0] idx_out
);

  logic        vld_r;
  logic [31:0] id_r;

  // valid flag: drop on clear, set on creation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (clr) begin
      vld_r <= 1'b0;
    end else if (wr_en) begin
      vld_r <= 1'b1;
    end
  end

  // id store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_r <= wr_id;
    end
  end

  // compare and pass along
  assign match   = vld_r && (id_r == q_id);
  assign hit_out = hit_in | match;
  assign idx_out = idx_in | (match ? EW'(INDEX) : '0);

endmodule

// ===== hw/rtl/array_access_coverage_tracker.sv =====
// ---------------------------------------------------------------------------
// array_access_coverage_tracker - per-array access statistics and coverage
// Tracks up to TRACKED_ENTRIES array ids with count, min/max index and a
// visited-slot bitmap; clear empties the table.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one item is an access record (in_op = record) or a
//   table clear (in_op = clear). Output channel out_*: exactly one result
//   item per input item, in order.
//   An item is taken when in_valid is high and in_stall low; in_stall is
//   high while an item is in work, so one item is in work at a time.
//   Work on an item is set by the registered read of the statistics and
//   bitmap memories followed by the write-back; the modulo of the index
//   by a slot count that is not a power of two adds two multiply steps.
//   The result is written to the output register when the last work step
//   finishes and holds while out_stall is high; the next item can be
//   taken while it waits, but finishes only once the register is free.
//   Reset empties the table and drops any pending result; no memory sweep
//   is needed since every entry is rewritten when it is created.
// ---------------------------------------------------------------------------
module array_access_coverage_tracker #(
  parameter int TRACKED_ENTRIES = 64,
  parameter int SLOTS_PER_ENTRY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [31:0]        in_array_id,
  input  logic signed [63:0] in_access_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_table_full,
  output logic [5:0]         out_entry_slot,
  output logic               out_new_entry,
  output logic               out_new_index_slot,
  output logic [31:0]        out_access_total,
  output logic [8:0]         out_distinct_slots,
  output logic [63:0]        out_lowest_index,
  output logic [63:0]        out_highest_index,
  output logic [15:0]        out_coverage_slot,
  output logic [6:0]         out_tracked_count
);

  import aact_pkg::*;

  localparam int N      = TRACKED_ENTRIES;
  localparam int S      = SLOTS_PER_ENTRY;
  localparam int EW     = (N > 1) ? $clog2(N) : 1;
  localparam int UW     = $clog2(N + 1);
  localparam int SW     = $clog2(S);
  localparam bit POW2   = ((S & (S - 1)) == 0);
  localparam logic [1:0] LAST_PH = POW2 ? 2'd1 : 2'd3;
  localparam logic [FOLD_W-1:0] RECIP = FOLD_W'((64'd1 << FOLD_W) / S);
  localparam int STAT_W = $bits(stat_t);

  // control
  logic [1:0]    ph_r, ph_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept, out_free, fin;

  // item in work
  logic              op_q;
  logic [31:0]       id_q;
  logic [63:0]       idx_q;
  logic              hit_q;
  logic [EW-1:0]     e_q;
  logic [HASH_W-1:0] m_q;
  logic [FOLD_W-1:0] fold_q;
  logic [FOLD_W-1:0] qe_q;
  logic [SW-1:0]     slot_q;

  // lookup chain
  logic              hit_c [N+1];
  logic [EW-1:0]     idx_c [N+1];
  logic [N-1:0]      match_v;
  logic [N-1:0]      cell_wr;
  logic              cell_clr;

  // memories
  logic [EW-1:0]     rd_addr;
  logic [STAT_W-1:0] rd_stat_raw;
  logic [S-1:0]      rd_row;
  logic              mem_we;
  stat_t             cur, upd;
  logic [S-1:0]      row, onehot, row_new;

  // finish path
  logic          create, full, seen;
  logic [EW-1:0] e_sel;
  logic [63:0]   hx, hy;
  logic [2*HASH_W-1:0] hprod;
  logic [15:0]   hash;

  // index reduction
  logic [19:0]           fold_term [8];
  logic [FOLD_W-1:0]     fold_sum;
  logic [2*FOLD_W-1:0]   qprod;
  logic [FOLD_W+DIST_W-1:0] qs;
  logic [FOLD_W-1:0]     rem, rem_c;

  assign in_stall = (ph_r != 2'd0);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fin      = (ph_r == LAST_PH) && out_free;

  // ---- lookup cells
  assign hit_c[0] = 1'b0;
  assign idx_c[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    aact_cell #(.EW(EW), .INDEX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (cell_clr),
      .wr_en   (cell_wr[i]),
      .wr_id   (id_q),
      .q_id    (in_array_id),
      .hit_in  (hit_c[i]),
      .idx_in  (idx_c[i]),
      .match   (match_v[i]),
      .hit_out (hit_c[i+1]),
      .idx_out (idx_c[i+1])
    );
  end

  // ---- slot fold: sum of byte times 256^k mod S
  for (genvar k = 0; k < 8; k++) begin : g_fold
    localparam logic [11:0] FW = fold_weight(k, S);
    assign fold_term[k] = 20'(in_access_index[8*k +: 8] * FW);
  end

  always_comb begin
    fold_sum = '0;
    for (int k = 0; k < 8; k++) begin
      fold_sum = fold_sum + FOLD_W'(fold_term[k]);
    end
  end

  // ---- hash pre-mix, keep the low bits that reach the result
  always_comb begin
    hx = {32'd0, in_array_id} ^ (64'(in_access_index) << HASH_SH_I);
    hy = hx ^ (hx >> HASH_SH_A);
  end

  // ---- capture the item at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= in_op;
      id_q  <= in_array_id;
      idx_q <= 64'(in_access_index);
      hit_q <= hit_c[N];
      e_q   <= idx_c[N];
      m_q   <= hy[HASH_W-1:0];
      fold_q <= fold_sum;
    end
  end

  // ---- slot: mask, or reciprocal estimate then one correction
  assign qprod = fold_q * RECIP;
  assign qs    = qe_q * DIST_W'(S);
  always_comb begin
    rem   = fold_q - qs[FOLD_W-1:0];
    rem_c = (rem >= FOLD_W'(S)) ? (rem - FOLD_W'(S)) : rem;
  end

  always_ff @(posedge clk) begin
    if (POW2) begin
      if (accept) begin
        slot_q <= SW'(in_access_index);
      end
    end else begin
      if (ph_r == 2'd1) begin
        qe_q <= qprod[2*FOLD_W-1:FOLD_W];
      end
      if (ph_r == 2'd2) begin
        slot_q <= SW'(rem_c);
      end
    end
  end

  // ---- memories, read at accept and written at finish
  assign rd_addr = hit_c[N] ? idx_c[N] : used_r[EW-1:0];

  aact_ram #(.WIDTH(STAT_W), .DEPTH(N)) u_stat_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (e_sel),
    .wdata (upd),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_stat_raw)
  );

  aact_ram #(.WIDTH(S), .DEPTH(N)) u_row_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (e_sel),
    .wdata (row_new),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  // ---- entry update
  always_comb begin
    create = (op_q == OP_RECORD) && !hit_q && (used_r != UW'(N));
    full   = (op_q == OP_RECORD) && !hit_q && (used_r == UW'(N));
    e_sel  = hit_q ? e_q : used_r[EW-1:0];

    if (create) begin
      cur.count    = '0;
      cur.min_idx  = '1;
      cur.max_idx  = '0;
      cur.distinct = '0;
      row          = '0;
    end else begin
      cur = stat_t'(rd_stat_raw);
      row = rd_row;
    end

    onehot         = '0;
    onehot[slot_q] = 1'b1;
    seen           = row[slot_q];
    row_new        = row | onehot;

    upd.count    = cur.count + 32'd1;
    upd.min_idx  = (idx_q < cur.min_idx) ? idx_q : cur.min_idx;
    upd.max_idx  = (idx_q > cur.max_idx) ? idx_q : cur.max_idx;
    upd.distinct = cur.distinct + (seen ? DIST_W'(0) : DIST_W'(1));

    mem_we   = fin && (op_q == OP_RECORD) && !full;
    cell_clr = fin && (op_q == OP_CLEAR);
    cell_wr  = '0;
    if (fin && create) begin
      cell_wr[used_r[EW-1:0]] = 1'b1;
    end
  end

  // ---- coverage hash
  assign hprod = m_q * HASH_MUL[HASH_W-1:0];
  assign hash  = hprod[15:0] ^ hprod[HASH_SH_B +: 16];

  // ---- control next state
  always_comb begin
    ph_nxt = ph_r;
    if (accept) begin
      ph_nxt = 2'd1;
    end else if (fin) begin
      ph_nxt = 2'd0;
    end else if ((ph_r != 2'd0) && (ph_r != LAST_PH)) begin
      ph_nxt = ph_r + 2'd1;
    end

    used_nxt = used_r;
    if (fin && (op_q == OP_CLEAR)) begin
      used_nxt = '0;
    end else if (fin && create) begin
      used_nxt = used_r + UW'(1);
    end

    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= 2'd0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (fin) begin
      if (op_q == OP_CLEAR) begin
        out_table_full     <= 1'b0;
        out_entry_slot     <= '0;
        out_new_entry      <= 1'b0;
        out_new_index_slot <= 1'b0;
        out_access_total   <= '0;
        out_distinct_slots <= '0;
        out_lowest_index   <= '0;
        out_highest_index  <= '0;
        out_coverage_slot  <= '0;
        out_tracked_count  <= '0;
      end else if (full) begin
        out_table_full     <= 1'b1;
        out_entry_slot     <= '0;
        out_new_entry      <= 1'b0;
        out_new_index_slot <= 1'b0;
        out_access_total   <= '0;
        out_distinct_slots <= '0;
        out_lowest_index   <= '0;
        out_highest_index  <= '0;
        out_coverage_slot  <= hash;
        out_tracked_count  <= 7'(used_r);
      end else begin
        out_table_full     <= 1'b0;
        out_entry_slot     <= 6'(e_sel);
        out_new_entry      <= create;
        out_new_index_slot <= !seen;
        out_access_total   <= upd.count;
        out_distinct_slots <= 9'(upd.distinct);
        out_lowest_index   <= upd.min_idx;
        out_highest_index  <= upd.max_idx;
        out_coverage_slot  <= hash;
        out_tracked_count  <= 7'(used_nxt);
      end
    end
  end

  assign out_valid = out_valid_r;

  // ---- assertions
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(N))
    else $error("tracked count beyond table size");

  a_unique_ids: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("array id held by more than one cell");

  a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && create) |=> (used_r == $past(used_r) + UW'(1)))
    else $error("entry creation did not advance tracked count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && (op_q == OP_CLEAR)) |=> (used_r == '0) && (match_v == '0))
    else $error("clear left entries in the table");

endmodule
